[rtl/rls_pkg.sv]
// Shared types and constants of the relocatable library splitter.
package rls_pkg;

	localparam int MAX_PARTS_DEF = 99;
	localparam logic [7:0] CLOSE_BYTE = 8'h9E;
	localparam logic [16:0] BYTES_MAX = 17'h1FFFF;
	localparam logic [16:0] MAX_LENGTH_RST = 17'd100;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [6:0] part_number;
		logic       part_closed;
		logic       stream_end;
		logic       last;
	} result_t;

	typedef struct packed {
		logic mod_end;
		logic file_end;
	} parse_flags_t;

endpackage

[rtl/rls_if.sv]
// Channel interfaces: input bytes, result items and the configuration write.
interface rls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface rls_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [6:0] part_number;
	logic       part_closed;
	logic       stream_end;
	logic       last;

	modport source (output valid, output out_byte, output part_number, output part_closed,
		output stream_end, output last, input ready);
	modport sink (input valid, input out_byte, input part_number, input part_closed,
		input stream_end, input last, output ready);
endinterface

interface rls_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/rel_library_splitter.sv]
// Top level of the relocatable library splitter.
// Takes one library byte per cycle, unless the result side holds it back, and returns
// it tagged with its part number; the eight bit-steps of the item parser run within
// that cycle between the input register and the result register. A byte that ends a
// module in a full part also yields a 0x9E closing item, so the input waits while
// that byte's second item leaves the result register. After the end-file item, bytes
// are taken and dropped until reset. Configuration writes are taken in any cycle.
module rel_library_splitter #(
	parameter int MAX_PARTS = rls_pkg::MAX_PARTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rls_in_if.sink     feed,
	rls_out_if.source  result,
	rls_cfg_if.sink    cfg
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic [16:0]           max_length_q;
	logic [16:0]           part_bytes_q;
	logic [6:0]            part_count_q;
	logic                  finished_q;
	logic                  can_load;
	logic                  move;
	logic                  advance;
	logic                  close;
	logic [16:0]           bytes_inc;
	rls_pkg::parse_flags_t flags;
	rls_pkg::result_t      first;
	rls_pkg::result_t      second;

	assign move       = valid_s1 && (finished_q || can_load);
	assign advance    = move && !finished_q;
	assign feed.ready = !valid_s1 || move;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.ready && feed.valid) byte_s1 <= feed.in_byte;
	end

	rls_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_byte (byte_s1),
		.flags   (flags)
	);

	assign bytes_inc = (part_bytes_q != rls_pkg::BYTES_MAX) ? part_bytes_q + 17'd1
		: part_bytes_q;
	assign close = flags.mod_end && (bytes_inc >= max_length_q)
		&& (part_count_q < 7'(MAX_PARTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= rls_pkg::MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			max_length_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_bytes_q <= 17'd0;
			part_count_q <= 7'd1;
			finished_q   <= 1'b0;
		end else if (advance) begin
			finished_q <= flags.file_end;
			if (close) begin
				part_count_q <= part_count_q + 7'd1;
				part_bytes_q <= 17'd0;
			end else begin
				part_bytes_q <= bytes_inc;
			end
		end
	end

	always_comb begin
		first.out_byte     = byte_s1;
		first.part_number  = part_count_q;
		first.part_closed  = 1'b0;
		first.stream_end   = flags.file_end;
		first.last         = !close;
		second.out_byte    = rls_pkg::CLOSE_BYTE;
		second.part_number = part_count_q;
		second.part_closed = 1'b1;
		second.stream_end  = 1'b0;
		second.last        = 1'b1;
	end

	rls_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.load_two (close),
		.first    (first),
		.second   (second),
		.can_load (can_load),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.part_closed |-> result.last && !result.stream_end)
		else $error("closing marker not the last item of its byte");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.stream_end |-> result.last)
		else $error("stream end item not the last item of its byte");
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared without reset");
	a_part_range: assert property (@(posedge clk) disable iff (!arst_n)
		part_count_q != 7'd0 && part_count_q <= 7'(MAX_PARTS))
		else $error("part count out of range");
	a_no_work_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !advance)
		else $error("parser advanced after stream end");
`endif

endmodule

[rtl/rls_parser.sv]
// Bitstream parser: state registers and the eight bit-steps of one byte.
module rls_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            in_byte,
	output rls_pkg::parse_flags_t flags
);

	localparam logic [2:0] PH_LEAD       = 3'd0;
	localparam logic [2:0] PH_TYPE       = 3'd1;
	localparam logic [2:0] PH_CTRL       = 3'd2;
	localparam logic [2:0] PH_BLEN       = 3'd3;
	localparam logic [2:0] PH_BCHARS     = 3'd4;
	localparam logic [2:0] PH_SKIP       = 3'd5;
	localparam logic [2:0] PH_SKIP_A_B   = 3'd6;
	localparam logic [2:0] PH_SKIP_A_END = 3'd7;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] bits_left;
		logic [3:0] field_value;
		logic [2:0] chars_left;
	} pstate_t;

	typedef struct packed {
		pstate_t st;
		logic    mod_end;
		logic    file_end;
	} step_t;

	function automatic pstate_t start_field(pstate_t s, logic [2:0] ph, logic [4:0] n);
		pstate_t r;
		r             = s;
		r.phase       = ph;
		r.bits_left   = n;
		r.field_value = 4'd0;
		return r;
	endfunction

	function automatic step_t step_bit(pstate_t s, logic b);
		step_t      r;
		logic [3:0] fv;
		logic [4:0] bl;
		logic [2:0] ch;
		r.st       = s;
		r.mod_end  = 1'b0;
		r.file_end = 1'b0;
		fv = {s.field_value[2:0], b};
		bl = (s.bits_left != 5'd0) ? s.bits_left - 5'd1 : 5'd0;
		ch = (s.chars_left != 3'd0) ? s.chars_left - 3'd1 : 3'd0;
		unique case (s.phase) inside
			PH_LEAD: begin
				if (b) r.st = start_field(s, PH_TYPE, 5'd2);
				else r.st = start_field(s, PH_SKIP, 5'd8);
			end
			PH_TYPE, PH_CTRL, PH_BLEN: begin
				r.st.field_value = fv;
				r.st.bits_left   = bl;
				if (bl == 5'd0) begin
					if (s.phase == PH_TYPE) begin
						if (fv != 4'd0) r.st = start_field(s, PH_SKIP, 5'd16);
						else r.st = start_field(s, PH_CTRL, 5'd4);
					end else if (s.phase == PH_CTRL) begin
						if (fv <= 4'd4) r.st = start_field(s, PH_BLEN, 5'd3);
						else if (fv <= 4'd8) r.st = start_field(s, PH_SKIP_A_B, 5'd18);
						else if (fv <= 4'd13) r.st = start_field(s, PH_SKIP, 5'd18);
						else if (fv == 4'd14) r.st = start_field(s, PH_SKIP_A_END, 5'd18);
						else begin
							r.file_end = 1'b1;
							r.st = start_field(s, PH_LEAD, 5'd0);
						end
					end else begin
						r.st.chars_left = fv[2:0];
						if (fv[2:0] == 3'd0) r.st = start_field(r.st, PH_LEAD, 5'd0);
						else r.st = start_field(r.st, PH_BCHARS, 5'd8);
					end
				end
			end
			PH_BCHARS: begin
				r.st.bits_left = bl;
				if (bl == 5'd0) begin
					r.st.chars_left = ch;
					if (ch == 3'd0) r.st = start_field(r.st, PH_LEAD, 5'd0);
					else r.st = start_field(r.st, PH_BCHARS, 5'd8);
				end
			end
			PH_SKIP, PH_SKIP_A_B, PH_SKIP_A_END: begin
				r.st.bits_left = bl;
				if (bl == 5'd0) begin
					if (s.phase == PH_SKIP_A_B) begin
						r.st = start_field(s, PH_BLEN, 5'd3);
					end else begin
						r.mod_end = (s.phase == PH_SKIP_A_END);
						r.st = start_field(s, PH_LEAD, 5'd0);
					end
				end
			end
		endcase
		return r;
	endfunction

	pstate_t state_q;
	pstate_t state_nxt;
	logic    mod_end;
	logic    file_end;

	always_comb begin
		step_t r;
		state_nxt = state_q;
		mod_end   = 1'b0;
		file_end  = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!mod_end && !file_end) begin
				r         = step_bit(state_nxt, in_byte[i]);
				state_nxt = r.st;
				mod_end   = r.mod_end;
				file_end  = r.file_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_LEAD, bits_left: 5'd0, field_value: 4'd0, chars_left: 3'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign flags.mod_end  = mod_end;
	assign flags.file_end = file_end;

endmodule

[rtl/rls_out_buf.sv]
// Two-slot result register: the pass-through item and an optional closing marker.
module rls_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             load_two,
	input  rls_pkg::result_t first,
	input  rls_pkg::result_t second,
	output logic             can_load,
	rls_out_if.source        result
);

	rls_pkg::result_t slot0_q;
	rls_pkg::result_t slot1_q;
	logic             valid0_q;
	logic             valid1_q;
	logic             take;

	assign take     = valid0_q && result.ready;
	assign can_load = !valid0_q || (take && !valid1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= 1'b0;
			valid1_q <= 1'b0;
		end else if (load) begin
			valid0_q <= 1'b1;
			valid1_q <= load_two;
		end else if (take) begin
			if (valid1_q) valid1_q <= 1'b0;
			else valid0_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= first;
			slot1_q <= second;
		end else if (take && valid1_q) begin
			slot0_q <= slot1_q;
		end
	end

	assign result.valid       = valid0_q;
	assign result.out_byte    = slot0_q.out_byte;
	assign result.part_number = slot0_q.part_number;
	assign result.part_closed = slot0_q.part_closed;
	assign result.stream_end  = slot0_q.stream_end;
	assign result.last        = slot0_q.last;

`ifndef SYNTHESIS
	a_pending_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		valid1_q |-> valid0_q)
		else $error("pending closing marker without a head item");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench of the library splitter: generated bitstreams checked against predicted items.
module tb;

	localparam int PART_LIMIT = rls_pkg::MAX_PARTS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_GAP = 14;
	localparam int PHASE_BYTES = 80;
	localparam int STALL_BYTES = 80;
	localparam int STALL_CYCLES = 400;
	localparam logic [16:0] LENGTH_HIGH = 17'd99999;

	localparam logic LEAD_SHORT = 1'b0;
	localparam logic LEAD_LONG = 1'b1;
	localparam logic [1:0] TYPE_CTRL = 2'd0;
	localparam logic [1:0] TYPE_SKIP_FIRST = 2'd1;
	localparam logic [1:0] TYPE_SKIP_LAST = 2'd3;
	localparam logic [3:0] CTRL_B_FIRST = 4'd0;
	localparam logic [3:0] CTRL_B_LAST = 4'd4;
	localparam logic [3:0] CTRL_AB_FIRST = 4'd5;
	localparam logic [3:0] CTRL_AB_LAST = 4'd8;
	localparam logic [3:0] CTRL_A_FIRST = 4'd9;
	localparam logic [3:0] CTRL_A_LAST = 4'd13;
	localparam logic [3:0] CTRL_MOD_END = 4'd14;
	localparam logic [3:0] CTRL_FILE_END = 4'd15;

	localparam int SHORT_BITS = 8;
	localparam int LONG_BITS = 16;
	localparam int TYPE_BITS = 2;
	localparam int CTRL_BITS = 4;
	localparam int A_BITS = 18;
	localparam int BLEN_BITS = 3;
	localparam int CHAR_BITS = 8;

	typedef enum logic [3:0] {
		PH_LEAD, PH_TYPE, PH_CTRL, PH_BLEN, PH_BCHARS, PH_SKIP, PH_SKIP_A_B, PH_SKIP_A_END
	} phase_e;

	typedef struct {
		phase_e     phase;
		logic [4:0] bits_left;
		logic [3:0] field;
		logic [2:0] chars_left;
	} parser_t;

	typedef struct {
		parser_t     ps;
		logic [16:0] part_bytes;
		logic [6:0]  part_count;
		logic        finished;
		logic [16:0] max_length;
	} splitter_t;

	logic clk;
	logic arst_n;

	rls_in_if  feed_ch ();
	rls_out_if result_ch ();
	rls_cfg_if cfg_ch ();

	rel_library_splitter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	splitter_t        spl;
	rls_pkg::result_t due_bytes [$];
	int               mismatches;
	int               cycle_count;
	int               bytes_sent;
	logic             tx_idle;
	logic             rx_idle;
	int               rx_hold;

	parser_t    gen_ps;
	logic [7:0] gen_acc;
	int         gen_nacc;
	logic       gen_skip;
	logic       gen_done;
	logic       end_allowed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void enter_field(inout parser_t p, input phase_e ph, input int n);
		p.phase = ph;
		p.bits_left = 5'(n);
		p.field = '0;
	endfunction

	function automatic void parse_bit(inout parser_t p, input logic b, output logic mod_end,
		output logic file_end);
		mod_end = 1'b0;
		file_end = 1'b0;
		case (p.phase)
			PH_LEAD: begin
				if (b)
					enter_field(p, PH_TYPE, TYPE_BITS);
				else
					enter_field(p, PH_SKIP, SHORT_BITS);
			end
			PH_TYPE, PH_CTRL, PH_BLEN: begin
				p.field = {p.field[2:0], b};
				if (p.bits_left != 0)
					p.bits_left--;
				if (p.bits_left == 0) begin
					if (p.phase == PH_TYPE) begin
						if (p.field != TYPE_CTRL)
							enter_field(p, PH_SKIP, LONG_BITS);
						else
							enter_field(p, PH_CTRL, CTRL_BITS);
					end else if (p.phase == PH_CTRL) begin
						if (p.field <= CTRL_B_LAST)
							enter_field(p, PH_BLEN, BLEN_BITS);
						else if (p.field <= CTRL_AB_LAST)
							enter_field(p, PH_SKIP_A_B, A_BITS);
						else if (p.field <= CTRL_A_LAST)
							enter_field(p, PH_SKIP, A_BITS);
						else if (p.field == CTRL_MOD_END)
							enter_field(p, PH_SKIP_A_END, A_BITS);
						else begin
							file_end = 1'b1;
							enter_field(p, PH_LEAD, 0);
						end
					end else begin
						p.chars_left = p.field[2:0];
						if (p.chars_left == 0)
							enter_field(p, PH_LEAD, 0);
						else
							enter_field(p, PH_BCHARS, CHAR_BITS);
					end
				end
			end
			PH_BCHARS: begin
				if (p.bits_left != 0)
					p.bits_left--;
				if (p.bits_left == 0) begin
					if (p.chars_left != 0)
						p.chars_left--;
					if (p.chars_left == 0)
						enter_field(p, PH_LEAD, 0);
					else
						enter_field(p, PH_BCHARS, CHAR_BITS);
				end
			end
			default: begin
				if (p.bits_left != 0)
					p.bits_left--;
				if (p.bits_left == 0) begin
					if (p.phase == PH_SKIP_A_B)
						enter_field(p, PH_BLEN, BLEN_BITS);
					else begin
						mod_end = (p.phase == PH_SKIP_A_END);
						enter_field(p, PH_LEAD, 0);
					end
				end
			end
		endcase
	endfunction

	function automatic void split_byte(input logic [7:0] b);
		logic             me;
		logic             fe;
		rls_pkg::result_t r;
		me = 1'b0;
		fe = 1'b0;
		if (spl.finished)
			return;
		if (spl.part_bytes != rls_pkg::BYTES_MAX)
			spl.part_bytes++;
		for (int i = 7; i >= 0 && !me && !fe; i--)
			parse_bit(spl.ps, b[i], me, fe);
		r.out_byte = b;
		r.part_number = spl.part_count;
		r.part_closed = 1'b0;
		r.stream_end = fe;
		r.last = 1'b1;
		if (fe)
			spl.finished = 1'b1;
		else if (me && spl.part_bytes >= spl.max_length && spl.part_count < PART_LIMIT) begin
			r.last = 1'b0;
			due_bytes.push_back(r);
			r.out_byte = rls_pkg::CLOSE_BYTE;
			r.part_closed = 1'b1;
			r.last = 1'b1;
			spl.part_count++;
			spl.part_bytes = '0;
		end
		due_bytes.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready)
			spl.max_length = cfg_ch.data;
		if (feed_ch.valid && feed_ch.ready)
			split_byte(feed_ch.in_byte);
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rls_pkg::result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (due_bytes.size() == 0) begin
				$error("item with none expected: out_byte %0h part_number %0d",
					result_ch.out_byte, result_ch.part_number);
				mismatches++;
			end else begin
				want = due_bytes.pop_front();
				check_field("out_byte", int'(want.out_byte), int'(result_ch.out_byte));
				check_field("part_number", int'(want.part_number),
					int'(result_ch.part_number));
				check_field("part_closed", int'(want.part_closed),
					int'(result_ch.part_closed));
				check_field("stream_end", int'(want.stream_end), int'(result_ch.stream_end));
				check_field("last", int'(want.last), int'(result_ch.last));
			end
		end
	end

	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			feed_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_ch.valid <= 1'b1;
		feed_ch.in_byte <= b;
		@(posedge clk);
		while (!feed_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic drain();
		int n;
		feed_ch.valid <= 1'b0;
		n = 0;
		while (due_bytes.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_bytes.size() != 0) begin
			$error("%0d expected items never arrived", due_bytes.size());
			mismatches++;
			due_bytes.delete();
		end
	endtask

	task automatic write_max_length(input logic [16:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_bit(input logic b);
		logic me;
		logic fe;
		if (!gen_skip && !gen_done) begin
			if (!end_allowed && gen_ps.phase == PH_CTRL && gen_ps.bits_left == 1 &&
				{gen_ps.field[2:0], b} == CTRL_FILE_END)
				b = ~b;
			parse_bit(gen_ps, b, me, fe);
			if (me || fe)
				gen_skip = 1'b1;
			if (fe)
				gen_done = 1'b1;
		end
		gen_acc = {gen_acc[6:0], b};
		gen_nacc++;
		if (gen_nacc == 8) begin
			gen_nacc = 0;
			gen_skip = 1'b0;
			send_byte(gen_acc);
		end
	endtask

	task automatic push_bits(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			push_bit(v[i]);
	endtask

	task automatic pad_byte();
		while (gen_nacc != 0)
			push_bit(1'($urandom_range(0, 1)));
	endtask

	task automatic resync();
		while (gen_ps.phase != PH_LEAD || gen_skip)
			push_bit(1'b0);
	endtask

	task automatic short_item(input logic [7:0] d);
		push_bits(32'(LEAD_SHORT), 1);
		push_bits(32'(d), SHORT_BITS);
	endtask

	task automatic long_item(input logic [1:0] kind, input logic [15:0] d);
		push_bits(32'(LEAD_LONG), 1);
		push_bits(32'(kind), TYPE_BITS);
		push_bits(32'(d), LONG_BITS);
	endtask

	task automatic control_item(input logic [3:0] c, input logic [17:0] a,
		input logic [2:0] nchars, input logic [7:0] ch);
		push_bits(32'(LEAD_LONG), 1);
		push_bits(32'(TYPE_CTRL), TYPE_BITS);
		push_bits(32'(c), CTRL_BITS);
		if (c > CTRL_B_LAST)
			push_bits(32'(a), A_BITS);
		if (c <= CTRL_AB_LAST) begin
			push_bits(32'(nchars), BLEN_BITS);
			repeat (nchars) push_bits(32'(ch), CHAR_BITS);
		end
		if (c == CTRL_MOD_END)
			pad_byte();
	endtask

	task automatic module_end();
		control_item(CTRL_MOD_END, 18'($urandom_range(0, 18'h3FFFF)), 3'd0, 8'h00);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 24)) push_bit(1'($urandom_range(0, 1)));
			resync();
		end else if (pick < 20)
			short_item(8'($urandom_range(0, 255)));
		else if (pick < 35)
			long_item(2'($urandom_range(TYPE_SKIP_FIRST, TYPE_SKIP_LAST)),
				16'($urandom_range(0, 16'hFFFF)));
		else if (pick < 47)
			module_end();
		else
			control_item(4'($urandom_range(CTRL_B_FIRST, CTRL_A_LAST)),
				18'($urandom_range(0, 18'h3FFFF)), 3'($urandom_range(0, 7)),
				8'($urandom_range(0, 255)));
	endtask

	task automatic test_default_length();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (25) module_end();
	endtask

	task automatic test_item_forms();
		short_item(8'hFF);
		short_item(8'h00);
		long_item(TYPE_SKIP_FIRST, 16'hFFFF);
		long_item(TYPE_SKIP_LAST, 16'h0000);
		control_item(CTRL_B_FIRST, 18'h00000, 3'd0, 8'h00);
		control_item(CTRL_B_LAST, 18'h00000, 3'd1, 8'hFF);
		control_item(CTRL_AB_FIRST, 18'h3FFFF, 3'd0, 8'h00);
		control_item(CTRL_AB_LAST, 18'h00000, 3'd2, 8'hA5);
		control_item(CTRL_A_FIRST, 18'h3FFFF, 3'd0, 8'h00);
		control_item(CTRL_A_LAST, 18'h00000, 3'd0, 8'h00);
		control_item(CTRL_MOD_END, 18'h3FFFF, 3'd0, 8'h00);
	endtask

	task automatic test_random_phases();
		logic [16:0] lengths [6];
		int          start;
		lengths = '{17'd0, 17'($urandom_range(1, 40)), rls_pkg::MAX_LENGTH_RST,
			17'($urandom_range(200, 1000)), LENGTH_HIGH, rls_pkg::BYTES_MAX};
		foreach (lengths[k]) begin
			write_max_length(lengths[k]);
			tx_idle = (k != 3);
			rx_idle = (k != 3) && (k != 4);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				random_item();
			resync();
			module_end();
		end
	endtask

	task automatic test_input_stall();
		int start;
		drain();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = STALL_CYCLES;
		start = bytes_sent;
		while (bytes_sent - start < STALL_BYTES)
			random_item();
		resync();
		module_end();
	endtask

	task automatic test_last_part();
		write_max_length(17'd0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (PART_LIMIT + 12) module_end();
	endtask

	task automatic test_stream_end();
		drain();
		end_allowed = 1'b1;
		long_item(TYPE_SKIP_FIRST, 16'($urandom_range(0, 16'hFFFF)));
		push_bits(32'(LEAD_LONG), 1);
		push_bits(32'(TYPE_CTRL), TYPE_BITS);
		push_bits(32'(CTRL_FILE_END), CTRL_BITS);
		pad_byte();
		send_byte(8'hFF);
		send_byte(8'h00);
		repeat (6) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		feed_ch.valid = 1'b0;
		feed_ch.in_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		mismatches = 0;
		cycle_count = 0;
		bytes_sent = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		spl.ps = '{PH_LEAD, 5'd0, 4'd0, 3'd0};
		spl.part_bytes = '0;
		spl.part_count = 7'd1;
		spl.finished = 1'b0;
		spl.max_length = rls_pkg::MAX_LENGTH_RST;
		gen_ps = '{PH_LEAD, 5'd0, 4'd0, 3'd0};
		gen_acc = '0;
		gen_nacc = 0;
		gen_skip = 1'b0;
		gen_done = 1'b0;
		end_allowed = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_length();
		test_item_forms();
		test_random_phases();
		test_input_stall();
		test_last_part();
		test_stream_end();
		drain();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
